[hw/rtl/set_assoc_cache_fifo_model_assert.svh]
// Assertion macros for the cache tag store checker.
`ifndef SET_ASSOC_CACHE_FIFO_MODEL_ASSERT_SVH
`define SET_ASSOC_CACHE_FIFO_MODEL_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SACF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define SACF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hw/rtl/sacf_pkg.sv]
// ----------------------------------------------------------------------------
// sacf_pkg
// Types, constants and register codes for the set-associative tag store.
// ----------------------------------------------------------------------------
package sacf_pkg;
    localparam int unsigned C_MAX_SETS  = 1024;
    localparam int unsigned C_MAX_WAYS  = 8;
    localparam int unsigned C_ADDR_BITS = 48;
    localparam int unsigned C_CNT_W     = 32;

    localparam logic [1:0] C_REG_OFFSET = 2'd0;
    localparam logic [1:0] C_REG_INDEX  = 2'd1;
    localparam logic [1:0] C_REG_WAYS   = 2'd2;

    localparam logic C_CMD_READ  = 1'b0;
    localparam logic C_CMD_WRITE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [47:0] address;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
        logic [31:0] read_count;
        logic [31:0] write_count;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } t_back_state;
endpackage

[hw/rtl/sacf_front.sv]
// ----------------------------------------------------------------------------
// sacf_front
// Splits the address into block address and set, resolves ways in use,
// and holds one classified item for the back end.
// ----------------------------------------------------------------------------
module sacf_front import sacf_pkg::*; #(
    parameter int unsigned MAX_SETS  = C_MAX_SETS,
    parameter int unsigned MAX_WAYS  = C_MAX_WAYS,
    parameter int unsigned ADDR_BITS = C_ADDR_BITS,
    localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int unsigned WAY_W = $clog2(MAX_WAYS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  t_in_item             i_item,
    input  logic [4:0]           i_offset_bits,
    input  logic [3:0]           i_index_bits,
    input  logic [3:0]           i_ways_in_use,
    input  logic                 i_pop,
    output logic                 o_valid,
    output logic                 o_write,
    output logic [ADDR_BITS-1:0] o_blk,
    output logic [SET_W-1:0]     o_set,
    output logic [WAY_W-1:0]     o_ways
);
    logic                 r_valid;
    logic                 r_write;
    logic [ADDR_BITS-1:0] r_blk;
    logic [SET_W-1:0]     r_set;
    logic [WAY_W-1:0]     r_ways;
    logic [ADDR_BITS-1:0] n_blk;
    logic [63:0]          w_addr;
    logic [15:0]          w_imask;
    logic [63:0]          w_idx;
    logic [WAY_W-1:0]     w_ways;

    always_comb begin
        w_addr = 64'(i_item.address);
        if (32'(i_offset_bits) < ADDR_BITS) begin
            n_blk = ADDR_BITS'(w_addr >> i_offset_bits);
        end else begin
            n_blk = '0;
        end
        w_imask = 16'((17'd1 << i_index_bits) - 17'd1);
        w_idx = 64'(n_blk) & 64'(w_imask);
        if (i_ways_in_use == 4'd0) begin
            w_ways = WAY_W'(1);
        end else if (32'(i_ways_in_use) > MAX_WAYS) begin
            w_ways = WAY_W'(MAX_WAYS);
        end else begin
            w_ways = WAY_W'(i_ways_in_use);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
        if (i_take) begin
            r_write <= (i_item.command == C_CMD_WRITE);
            r_blk   <= n_blk;
            r_set   <= (MAX_SETS > 1) ? SET_W'(w_idx % 64'(MAX_SETS)) : '0;
            r_ways  <= w_ways;
        end
    end

    assign o_valid = r_valid;
    assign o_write = r_write;
    assign o_blk   = r_blk;
    assign o_set   = r_set;
    assign o_ways  = r_ways;
endmodule

[hw/rtl/sacf_back.sv]
// ----------------------------------------------------------------------------
// sacf_back
// Clears every set after reset, then reads the set's row, compares tags, picks a victim,
// writes the row back on a miss and updates the running totals.
// ----------------------------------------------------------------------------
module sacf_back import sacf_pkg::*; #(
    parameter int unsigned MAX_SETS  = C_MAX_SETS,
    parameter int unsigned MAX_WAYS  = C_MAX_WAYS,
    parameter int unsigned ADDR_BITS = C_ADDR_BITS,
    localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int unsigned WAY_W = $clog2(MAX_WAYS + 1),
    localparam int unsigned PTR_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_write,
    input  logic [ADDR_BITS-1:0] i_blk,
    input  logic [SET_W-1:0]     i_set,
    input  logic [WAY_W-1:0]     i_ways,
    output logic                 o_pop,
    output logic                 o_ready,
    output logic                 o_strobe,
    output t_out_item            o_result
);
    localparam int unsigned REM_W = WAY_W + PTR_W;

    logic [MAX_WAYS*ADDR_BITS-1:0] tag_mem [MAX_SETS];
    logic [MAX_WAYS-1:0]           val_mem [MAX_SETS];
    logic [PTR_W-1:0]              ptr_mem [MAX_SETS];

    t_back_state r_state, n_state;
    logic [SET_W-1:0]              r_clr;
    logic [MAX_WAYS*ADDR_BITS-1:0] r_tags;
    logic [MAX_WAYS-1:0]           r_vals;
    logic [PTR_W-1:0]              r_ptr;
    logic [31:0] r_hits, r_miss, r_reads, r_wrs;
    logic        r_strobe;
    t_out_item   r_result;

    logic                 w_hit;
    logic                 w_free;
    logic [PTR_W-1:0]     w_free_way;
    logic [PTR_W-1:0]     w_victim;
    logic [PTR_W-1:0]     w_pmod;
    logic [REM_W-1:0]     w_rem;
    logic [PTR_W-1:0]     n_ptr;
    logic [MAX_WAYS-1:0]  w_vals;
    logic [MAX_WAYS*ADDR_BITS-1:0] w_tags;
    logic w_clr_go, w_rd, w_upd;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (r_clr == SET_W'(MAX_SETS - 1)) n_state = ST_IDLE;
            ST_IDLE:   if (i_valid) n_state = ST_READ;
            ST_READ:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        w_clr_go = 1'b0;
        w_rd = 1'b0;
        w_upd = 1'b0;
        case (r_state)
            ST_CLEAR:  w_clr_go = 1'b1;
            ST_IDLE:   w_rd = i_valid;
            ST_UPDATE: w_upd = 1'b1;
            default:   w_rd = 1'b0;
        endcase
    end

    always_comb begin
        w_hit = 1'b0;
        w_free = 1'b0;
        w_free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (WAY_W'(w) < i_ways) begin
                if (r_vals[w] && r_tags[w*ADDR_BITS +: ADDR_BITS] == i_blk) begin
                    w_hit = 1'b1;
                end
                if (!r_vals[w]) begin
                    w_free = 1'b1;
                    w_free_way = PTR_W'(w);
                end
            end
        end
        // pointer modulo ways by shifted compare and subtract
        w_rem = REM_W'(r_ptr);
        for (int k = PTR_W - 1; k >= 0; k--) begin
            if (w_rem >= (REM_W'(i_ways) << k)) begin
                w_rem = w_rem - (REM_W'(i_ways) << k);
            end
        end
        w_pmod = PTR_W'(w_rem);
        n_ptr = r_ptr;
        if (w_free) begin
            w_victim = w_free_way;
        end else begin
            w_victim = w_pmod;
            n_ptr = (WAY_W'(w_pmod) + WAY_W'(1) == i_ways) ? '0 : PTR_W'(w_pmod + 1'b1);
        end
        w_vals = r_vals;
        w_tags = r_tags;
        w_vals[w_victim] = 1'b1;
        w_tags[w_victim*ADDR_BITS +: ADDR_BITS] = i_blk;
    end

    always_ff @(posedge i_clk) begin
        if (w_clr_go) begin
            val_mem[r_clr] <= '0;
            ptr_mem[r_clr] <= '0;
        end else if (w_upd && !w_hit) begin
            val_mem[i_set] <= w_vals;
            tag_mem[i_set] <= w_tags;
            ptr_mem[i_set] <= n_ptr;
        end
        if (w_rd) begin
            r_tags <= tag_mem[i_set];
            r_vals <= val_mem[i_set];
            r_ptr  <= ptr_mem[i_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_hits   <= '0;
            r_miss   <= '0;
            r_reads  <= '0;
            r_wrs    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_upd;
            if (w_clr_go) r_clr <= r_clr + 1'b1;
            if (w_upd) begin
                if (w_hit) r_hits <= r_hits + 32'd1;
                else begin
                    r_miss  <= r_miss + 32'd1;
                    r_reads <= r_reads + 32'd1;
                end
                if (i_write) r_wrs <= r_wrs + 32'd1;
            end
        end
        if (w_upd) begin
            r_result.hit         <= w_hit;
            r_result.mem_read    <= !w_hit;
            r_result.mem_write   <= i_write;
            r_result.hit_count   <= r_hits + 32'(w_hit);
            r_result.miss_count  <= r_miss + 32'(!w_hit);
            r_result.read_count  <= r_reads + 32'(!w_hit);
            r_result.write_count <= r_wrs + 32'(i_write);
        end
    end

    assign o_pop    = w_upd;
    assign o_ready  = (r_state != ST_CLEAR);
    assign o_strobe = r_strobe;
    assign o_result = r_result;
endmodule

[hw/rtl/set_assoc_cache_fifo_model.sv]
// Each item passes a row read, a tag compare and a write back; o_done rises as busy drops.
// No new item is taken while busy is high. busy is high while an item is held.
// After reset a clearing pass over all MAX_SETS sets runs with busy high.
// The receiver cannot stall; results are strobed for one cycle.
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_model
// Write-through set-associative tag store with FIFO replacement.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_model import sacf_pkg::*; #(
    parameter int unsigned MAX_SETS  = C_MAX_SETS,
    parameter int unsigned MAX_WAYS  = C_MAX_WAYS,
    parameter int unsigned ADDR_BITS = C_ADDR_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in_item   i_item,
    output logic       o_done,
    output t_out_item  o_result,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [4:0] i_cfg_data
);
    localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int unsigned WAY_W = $clog2(MAX_WAYS + 1);

    logic [4:0] r_offset_bits;
    logic [3:0] r_index_bits;
    logic [3:0] r_ways_in_use;
    logic                 w_valid, w_write, w_pop, w_ready, w_take;
    logic [ADDR_BITS-1:0] w_blk;
    logic [SET_W-1:0]     w_set;
    logic [WAY_W-1:0]     w_ways;

    assign busy   = w_valid || !w_ready;
    assign w_take = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= 5'd4;
            r_index_bits  <= 4'd0;
            r_ways_in_use <= 4'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                C_REG_OFFSET: r_offset_bits <= i_cfg_data;
                C_REG_INDEX:  r_index_bits  <= i_cfg_data[3:0];
                C_REG_WAYS:   r_ways_in_use <= i_cfg_data[3:0];
                default:      r_offset_bits <= r_offset_bits;
            endcase
        end
    end

    sacf_front #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .ADDR_BITS(ADDR_BITS)) u_front (
        .i_clk, .i_rst_n, .i_take(w_take), .i_item,
        .i_offset_bits(r_offset_bits), .i_index_bits(r_index_bits),
        .i_ways_in_use(r_ways_in_use), .i_pop(w_pop),
        .o_valid(w_valid), .o_write(w_write), .o_blk(w_blk), .o_set(w_set),
        .o_ways(w_ways)
    );

    sacf_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .ADDR_BITS(ADDR_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_valid), .i_write(w_write), .i_blk(w_blk),
        .i_set(w_set), .i_ways(w_ways), .o_pop(w_pop), .o_ready(w_ready),
        .o_strobe(o_done), .o_result
    );
endmodule

[hw/rtl/sacf_checker.sv]
// ----------------------------------------------------------------------------
// sacf_checker
// Port-level checks on the tag store's handshake and results.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_fifo_model_assert.svh"
module sacf_checker import sacf_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_done,
    input t_out_item o_result
);
    `SACF_ASSERT_IMP(a_hit_xor_read, i_clk, i_rst_n, o_done,
        o_result.hit != o_result.mem_read, "hit and mem_read must differ")
    `SACF_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, start && !busy,
        busy, "busy must rise after an item is taken")
    `SACF_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done,
        !o_done, "results are at least two cycles apart")
endmodule

bind set_assoc_cache_fifo_model sacf_checker u_chk (
    .i_clk, .i_rst_n, .start, .busy, .o_done, .o_result
);
